FILE: sv/cbbc_pkg.sv
// Shared types and constants for the comment- and quote-aware bracket counter.
// No dependencies; every other file imports this package.
package cbbc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_W           = 16;
    localparam int NUM_TALLY       = 10;
    localparam int MODE_W          = 4;
    localparam int DATA_W          = NUM_TALLY * OUT_W;

    // lexer mode codes
    localparam logic [MODE_W-1:0] MODE_PLAIN         = 4'd0;
    localparam logic [MODE_W-1:0] MODE_LINE_COMMENT  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK_COMMENT = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SINGLE_QUOTE  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DOUBLE_QUOTE  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_COMMENT_ENTRY = 4'd5;
    localparam logic [MODE_W-1:0] MODE_COMMENT_EXIT  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_QUOTE_ENTRY   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_QUOTE_EXIT    = 4'd8;

    // tally slots, in output order
    localparam int T_LPAREN  = 0;
    localparam int T_RPAREN  = 1;
    localparam int T_LSQUARE = 2;
    localparam int T_RSQUARE = 3;
    localparam int T_LCURLY  = 4;
    localparam int T_RCURLY  = 5;
    localparam int T_QSTART  = 6;
    localparam int T_QSTOP   = 7;
    localparam int T_CSTART  = 8;
    localparam int T_CSTOP   = 9;

    // characters of interest
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NL      = 8'h0A;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [NUM_TALLY-1:0] bump;
    } lex_res_t;

endpackage

FILE: sv/cbbc_lex_step.sv
// One classification step of the lexer: next mode and which tally to bump.
// Depends on cbbc_pkg.
module cbbc_lex_step (
    input  logic [cbbc_pkg::MODE_W-1:0] mode,
    input  logic [7:0]                  prev,
    input  logic [7:0]                  cur,
    input  logic                        has_next,
    input  logic [7:0]                  nxt,
    output cbbc_pkg::lex_res_t          res
);
    import cbbc_pkg::*;

    logic [MODE_W-1:0] m;

    always_comb
    begin
        m = mode;
        case (mode)
            MODE_PLAIN:
            begin
                if (cur == CH_SLASH && has_next && (nxt == CH_STAR || nxt == CH_SLASH))
                    m = MODE_COMMENT_ENTRY;
                else if (cur == CH_SQUOTE || cur == CH_DQUOTE)
                    m = MODE_QUOTE_ENTRY;
                else
                    m = MODE_PLAIN;
            end
            MODE_COMMENT_ENTRY:
                m = (cur == CH_SLASH) ? MODE_LINE_COMMENT : MODE_BLOCK_COMMENT;
            MODE_QUOTE_ENTRY:
                m = (prev == CH_SQUOTE) ? MODE_SINGLE_QUOTE : MODE_DOUBLE_QUOTE;
            MODE_BLOCK_COMMENT:
            begin
                if (prev == CH_STAR && cur == CH_SLASH)
                    m = MODE_COMMENT_EXIT;
            end
            MODE_LINE_COMMENT:
            begin
                if (cur == CH_NL)
                    m = MODE_PLAIN;
            end
            MODE_SINGLE_QUOTE:
            begin
                if (prev != CH_BSLASH && cur == CH_SQUOTE)
                    m = MODE_QUOTE_EXIT;
            end
            MODE_DOUBLE_QUOTE:
            begin
                if (prev != CH_BSLASH && cur == CH_DQUOTE)
                    m = MODE_QUOTE_EXIT;
            end
            MODE_COMMENT_EXIT, MODE_QUOTE_EXIT:
                m = MODE_PLAIN;
            default:
                m = mode;
        endcase
    end

    always_comb
    begin
        res.mode = m;
        res.bump = '0;
        if (m == MODE_PLAIN)
        begin
            case (cur)
                CH_LPAREN:  res.bump[T_LPAREN]  = 1'b1;
                CH_RPAREN:  res.bump[T_RPAREN]  = 1'b1;
                CH_LSQUARE: res.bump[T_LSQUARE] = 1'b1;
                CH_RSQUARE: res.bump[T_RSQUARE] = 1'b1;
                CH_LCURLY:  res.bump[T_LCURLY]  = 1'b1;
                CH_RCURLY:  res.bump[T_RCURLY]  = 1'b1;
                default:    res.bump = '0;
            endcase
        end
        else if (m == MODE_QUOTE_ENTRY)
            res.bump[T_QSTART] = 1'b1;
        else if (m == MODE_QUOTE_EXIT)
            res.bump[T_QSTOP] = 1'b1;
        else if (mode == MODE_COMMENT_ENTRY && m == MODE_BLOCK_COMMENT)
            res.bump[T_CSTART] = 1'b1;
        else if (m == MODE_COMMENT_EXIT)
            res.bump[T_CSTOP] = 1'b1;
    end

endmodule

FILE: sv/cbbc_tally.sv
// Ten saturating counters, each bumped by up to two per word.
// Depends on cbbc_pkg.
module cbbc_tally #(
    parameter int COUNT_WIDTH = cbbc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        clear,
    input  logic [cbbc_pkg::NUM_TALLY-1:0]              bump_a,
    input  logic [cbbc_pkg::NUM_TALLY-1:0]              bump_b,
    output logic [cbbc_pkg::NUM_TALLY-1:0][COUNT_WIDTH-1:0] sum
);
    import cbbc_pkg::*;

    logic [NUM_TALLY-1:0][COUNT_WIDTH-1:0] tally_reg;
    logic [NUM_TALLY-1:0][COUNT_WIDTH-1:0] tally_next;

    for (genvar k = 0; k < NUM_TALLY; k++)
    begin : g_lane
        logic [COUNT_WIDTH:0] raw;
        assign raw = {1'b0, tally_reg[k]}
                   + {{COUNT_WIDTH{1'b0}}, bump_a[k]}
                   + {{COUNT_WIDTH{1'b0}}, bump_b[k]};
        // clamp at the top once the carry appears
        assign sum[k] = raw[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : raw[COUNT_WIDTH-1:0];
        assign tally_next[k] = clear ? '0 : sum[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tally_reg <= '0;
        else if (en)
            tally_reg <= tally_next;
    end

endmodule

FILE: sv/c_bracket_balance_counter_top.sv
// Top level of the comment- and quote-aware bracket counter for C text.
// Depends on cbbc_pkg, cbbc_lex_step and cbbc_tally.
//
//  channel | dir | tdata                      | tlast
//  s_*     | in  | text_byte [7:0]            | end_of_text
//  m_*     | out | ten 16-bit counts [159:0]  | -
//
// One word a cycle is taken, save that a final word waits while an unread result is held:
// a word is registered in the input register, then two lexer steps (held byte with
// lookahead, last byte without) feed the counters. A text's result is registered in the
// output register and waits; words that do not end a text keep flowing while it waits.
// Reset clears the lexer, the held byte and all counters; no clearing pass is needed.
module c_bracket_balance_counter_top #(
    parameter int COUNT_WIDTH = cbbc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // text_byte [7:0]
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cbbc_pkg::DATA_W-1:0] m_tdata    // open_paren, close_paren, open_square,
                                                   // close_square, open_curly, close_curly,
                                                   // quote_start, quote_stop, comment_start,
                                                   // comment_stop: 16 bits each, lowest first
);
    import cbbc_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              proc_fire;

    logic [MODE_W-1:0] mode_reg;
    logic [7:0]        prev_reg;
    logic [7:0]        pend_reg;
    logic              pend_valid_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;

    lex_res_t          res_a;
    lex_res_t          res_b;
    logic [MODE_W-1:0] mode_a;
    logic [7:0]        prev_a;
    logic [NUM_TALLY-1:0] bump_a;
    logic [NUM_TALLY-1:0] bump_b;
    logic [NUM_TALLY-1:0][COUNT_WIDTH-1:0] sum;

    // a final word may only move on when the output register is free or being read
    assign proc_fire = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    cbbc_lex_step u_step_a (
        .mode     (mode_reg),
        .prev     (prev_reg),
        .cur      (pend_reg),
        .has_next (1'b1),
        .nxt      (in_byte_reg),
        .res      (res_a)
    );

    // skip the held-byte step when nothing is held
    assign mode_a = pend_valid_reg ? res_a.mode : mode_reg;
    assign prev_a = pend_valid_reg ? pend_reg : prev_reg;
    assign bump_a = pend_valid_reg ? res_a.bump : '0;

    cbbc_lex_step u_step_b (
        .mode     (mode_a),
        .prev     (prev_a),
        .cur      (in_byte_reg),
        .has_next (1'b0),
        .nxt      (8'h00),
        .res      (res_b)
    );

    assign bump_b = in_last_reg ? res_b.bump : '0;

    cbbc_tally #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (proc_fire),
        .clear  (in_last_reg),
        .bump_a (bump_a),
        .bump_b (bump_b),
        .sum    (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_PLAIN;
            prev_reg       <= 8'h00;
            pend_reg       <= 8'h00;
            pend_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                mode_reg       <= MODE_PLAIN;
                prev_reg       <= 8'h00;
                pend_reg       <= 8'h00;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                mode_reg       <= mode_a;
                prev_reg       <= prev_a;
                pend_reg       <= in_byte_reg;
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // fit each count into its 16-bit field
    for (genvar k = 0; k < NUM_TALLY; k++)
    begin : g_pack
        logic [COUNT_WIDTH+OUT_W-1:0] ext;
        assign ext = {{OUT_W{1'b0}}, sum[k]};
        assign out_data_next[k*OUT_W +: OUT_W] = ext[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: tb/sv/c_bracket_balance_counter_top_tb.sv
// Self-checking bench for the bracket counter: streams C-like text, predicts the ten counts.
// Depends on cbbc_pkg and c_bracket_balance_counter_top.
module c_bracket_balance_counter_top_tb;
    import cbbc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int BURST_LEN   = 40;
    localparam int RANDOM_WORDS = 1100;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;
        bit         rush;
    } text_word_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    c_bracket_balance_counter_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    text_word_t        text_q[$];
    logic [7:0]        text_buf[$];
    logic [DATA_W-1:0] expected_counts[$];

    // lexer copy kept by the bench
    logic [MODE_W-1:0] lex_mode    = MODE_PLAIN;
    logic [7:0]        lex_prev    = '0;
    logic [7:0]        lex_held    = '0;
    bit                lex_held_ok = 1'b0;
    logic [OUT_W-1:0]  lex_tally[NUM_TALLY];

    string count_name[NUM_TALLY] = '{"open_paren", "close_paren", "open_square",
                                     "close_square", "open_curly", "close_curly",
                                     "quote_start", "quote_stop", "comment_start",
                                     "comment_stop"};

    int         bytes_sent    = 0;
    int         words_total   = 0;
    int         texts_total   = 0;
    int         texts_checked = 0;
    int         mismatches    = 0;
    int         cycles        = 0;
    int         tx_gap        = 0;
    int         rx_hold       = 0;
    bit         tx_live       = 1'b0;
    bit         tx_steady     = 1'b0;
    bit         rx_steady     = 1'b0;
    text_word_t tx_word       = '{8'h00, 1'b0, 1'b0, 1'b0};

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("c_bracket_balance_counter_top verification failed");
            $finish;
        end
    end

    function automatic logic [MODE_W-1:0] lex_next(input logic [7:0] prev,
                                                  input logic [7:0] cur,
                                                  input bit has_nxt,
                                                  input logic [7:0] nxt,
                                                  input logic [MODE_W-1:0] mode);
        if (mode == MODE_PLAIN)
        begin
            if (cur == CH_SLASH && has_nxt && (nxt == CH_STAR || nxt == CH_SLASH))
                return MODE_COMMENT_ENTRY;
            if (cur == CH_SQUOTE || cur == CH_DQUOTE)
                return MODE_QUOTE_ENTRY;
            return MODE_PLAIN;
        end
        if (mode == MODE_COMMENT_ENTRY)
            return (cur == CH_SLASH) ? MODE_LINE_COMMENT : MODE_BLOCK_COMMENT;
        // the opening quote is the previous byte by now
        if (mode == MODE_QUOTE_ENTRY)
            return (prev == CH_SQUOTE) ? MODE_SINGLE_QUOTE : MODE_DOUBLE_QUOTE;
        if (mode == MODE_BLOCK_COMMENT && prev == CH_STAR && cur == CH_SLASH)
            return MODE_COMMENT_EXIT;
        if (mode == MODE_LINE_COMMENT && cur == CH_NL)
            return MODE_PLAIN;
        if (mode == MODE_SINGLE_QUOTE && prev != CH_BSLASH && cur == CH_SQUOTE)
            return MODE_QUOTE_EXIT;
        if (mode == MODE_DOUBLE_QUOTE && prev != CH_BSLASH && cur == CH_DQUOTE)
            return MODE_QUOTE_EXIT;
        if (mode == MODE_COMMENT_EXIT || mode == MODE_QUOTE_EXIT)
            return MODE_PLAIN;
        return mode;
    endfunction

    task automatic tally_bump(input int slot);
        if (lex_tally[slot] != '1)
            lex_tally[slot]++;
    endtask

    task automatic lex_clear();
        lex_mode    = MODE_PLAIN;
        lex_prev    = '0;
        lex_held    = '0;
        lex_held_ok = 1'b0;
        for (int k = 0; k < NUM_TALLY; k++)
            lex_tally[k] = '0;
    endtask

    task automatic lex_char(input logic [7:0] cur, input bit has_nxt, input logic [7:0] nxt);
        logic [MODE_W-1:0] nm;
        nm = lex_next(lex_prev, cur, has_nxt, nxt, lex_mode);
        if (nm == MODE_PLAIN)
        begin
            case (cur)
                CH_LPAREN:  tally_bump(T_LPAREN);
                CH_RPAREN:  tally_bump(T_RPAREN);
                CH_LSQUARE: tally_bump(T_LSQUARE);
                CH_RSQUARE: tally_bump(T_RSQUARE);
                CH_LCURLY:  tally_bump(T_LCURLY);
                CH_RCURLY:  tally_bump(T_RCURLY);
                default:    ;
            endcase
        end
        else if (nm == MODE_QUOTE_ENTRY)
            tally_bump(T_QSTART);
        else if (nm == MODE_QUOTE_EXIT)
            tally_bump(T_QSTOP);
        else if (lex_mode == MODE_COMMENT_ENTRY && nm == MODE_BLOCK_COMMENT)
            tally_bump(T_CSTART);
        else if (nm == MODE_COMMENT_EXIT)
            tally_bump(T_CSTOP);
        lex_mode = nm;
        lex_prev = cur;
    endtask

    // advance the lexer copy by one accepted word; queue the counts at end of text
    task automatic feed_byte(input logic [7:0] ch, input logic last);
        logic [DATA_W-1:0] counts;
        if (lex_held_ok)
            lex_char(lex_held, 1'b1, ch);
        lex_held    = ch;
        lex_held_ok = 1'b1;
        if (last)
        begin
            lex_char(lex_held, 1'b0, 8'h00);
            for (int k = 0; k < NUM_TALLY; k++)
                counts[k*OUT_W +: OUT_W] = lex_tally[k];
            expected_counts.push_back(counts);
            lex_clear();
        end
    endtask

    task automatic check_counts(input logic [DATA_W-1:0] got);
        logic [DATA_W-1:0] want;
        if (expected_counts.size() == 0)
        begin
            if (mismatches < 10)
                $display("[%0t] count set with none expected: %h", $realtime, got);
            mismatches++;
        end
        else
        begin
            want = expected_counts.pop_front();
            texts_checked++;
            for (int k = 0; k < NUM_TALLY; k++)
            begin
                if (got[k*OUT_W +: OUT_W] !== want[k*OUT_W +: OUT_W])
                begin
                    if (mismatches < 10)
                        $display("[%0t] text %0d %s: expected %0d, got %0d", $realtime,
                                 texts_checked, count_name[k], want[k*OUT_W +: OUT_W],
                                 got[k*OUT_W +: OUT_W]);
                    mismatches++;
                end
            end
        end
    endtask

    function automatic int idle_len(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sender: one word held on the bus until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap = 0;
            lex_clear();
        end
        else
        begin
            tx_live = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                feed_byte(tx_word.ch, tx_word.last);
                bytes_sent++;
                tx_live = 1'b0;
                if ($urandom_range(0, 63) == 0)
                    tx_steady = !tx_steady;
                tx_gap = tx_word.rush ? 0 : idle_len(tx_steady);
            end
            if (!tx_live)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (text_q.size() != 0 &&
                         (!text_q[0].drain || expected_counts.size() == 0))
                begin
                    tx_word = text_q.pop_front();
                    tx_live = 1'b1;
                end
            end
            s_tvalid <= tx_live;
            s_tdata  <= tx_word.ch;
            s_tlast  <= tx_word.last;
        end
    end

    // receiver: check each count set, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_counts(m_tdata);
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_hold = idle_len(rx_steady);
            end
        end
    end

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_char(input string alphabet);
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    // move the buffered text into the word queue, last flag on its final byte
    task automatic commit_text(input bit drain, input bit rush);
        text_word_t w;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            w.ch    = text_buf[i];
            w.last  = (i == text_buf.size() - 1);
            w.drain = drain && (i == 0);
            w.rush  = rush;
            text_q.push_back(w);
        end
        words_total += text_buf.size();
        texts_total++;
        text_buf.delete();
    endtask

    // append one lexical piece: mostly well-formed, some broken or raw noise
    task automatic add_piece();
        string inner;
        int    r;
        int    n;
        inner = "ab ()[]{}/*'\"\\\n";
        r = $urandom_range(0, 99);
        n = $urandom_range(0, 6);
        if (r < 30)
            text_buf.push_back(pick_char("()[]{}"));
        else if (r < 42)
            text_buf.push_back(pick_char("xyz_ ;=\n*/"));
        else if (r < 55)
        begin
            text_buf.push_back(CH_DQUOTE);
            for (int i = 0; i < n; i++)
                text_buf.push_back(pick_char(inner));
            text_buf.push_back(CH_DQUOTE);
        end
        else if (r < 63)
        begin
            text_buf.push_back(CH_SQUOTE);
            if ($urandom_range(0, 2) == 0)
                text_buf.push_back(CH_BSLASH);
            text_buf.push_back(pick_char(inner));
            text_buf.push_back(CH_SQUOTE);
        end
        else if (r < 75)
        begin
            put_str("/*");
            for (int i = 0; i < n; i++)
                text_buf.push_back(pick_char(inner));
            put_str("*/");
        end
        else if (r < 83)
        begin
            put_str("//");
            for (int i = 0; i < n; i++)
                text_buf.push_back(pick_char("ab(){}[]*/'\""));
            text_buf.push_back(CH_NL);
        end
        else if (r < 93)
            text_buf.push_back(pick_char("/*'\"\\\n"));
        else
            text_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int pieces;

        // directed: one-byte text, block comment, back-to-back literals with an
        // escaped quote, line comment ending on a slash with no lookahead, byte extremes
        put_str("(");
        commit_text(1'b0, 1'b0);
        put_str("/*(*/)");
        commit_text(1'b0, 1'b0);
        put_str("'a'\"b\\\"\"[");
        commit_text(1'b0, 1'b0);
        put_str("//{\n}/");
        commit_text(1'b0, 1'b0);
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        commit_text(1'b0, 1'b0);

        while (words_total < 24 + RANDOM_WORDS)
        begin
            pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                 : $urandom_range(1, 12);
            for (int i = 0; i < pieces; i++)
                add_piece();
            commit_text(texts_total == 5 || $urandom_range(0, 7) == 0, 1'b0);
        end

        // one text sent with no gaps between its words
        for (int i = 0; i < BURST_LEN; i++)
            text_buf.push_back(CH_LPAREN);
        text_buf.push_back(CH_RCURLY);
        commit_text(1'b1, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent != words_total || expected_counts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d texts; %0d count sets checked, %0d mismatches.",
                 bytes_sent, texts_total, texts_checked, mismatches);
        $display("Texts mixed comments, literals, escapes and raw bytes; one ran back to back.");
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("c_bracket_balance_counter_top verification clean");
        else
            $display("c_bracket_balance_counter_top verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/cbbc_pkg.sv
sv/cbbc_lex_step.sv
sv/cbbc_tally.sv
sv/c_bracket_balance_counter_top.sv
tb/sv/c_bracket_balance_counter_top_tb.sv
